// ----- rtl/efc_pkg.sv -----
// ----------------------------------------------------------------------------
// efc_pkg
// Shared types and constants for the exact fraction comparator.
// ----------------------------------------------------------------------------
package efc_pkg;

  // Significant bits of each operand; upper field bits are ignored.
  localparam int unsigned OperandWidth = 64;
  localparam int unsigned CntWidth     = $clog2(OperandWidth);

  typedef struct packed {
    logic [63:0] left_num;
    logic [63:0] left_den;
    logic [63:0] right_num;
    logic [63:0] right_den;
  } in_t;

  typedef struct packed {
    logic at_least;
    logic zero_denominator;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // take a new operand beat, clear the expansion
    logic step;     // one restoring-division bit on both sides
    logic advance;  // reciprocal step: den -> num, rem -> den
    logic out_load; // copy result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic zero_den; // a denominator is zero
    logic decided;  // quotients/remainders settle the comparison
  } status_t;

endpackage

// ----- rtl/efc_datapath.sv -----
// ----------------------------------------------------------------------------
// efc_datapath
// Operand registers, twin bit-serial dividers and the decision logic.
// ----------------------------------------------------------------------------
module efc_datapath import efc_pkg::*; (
  input  logic    clk_i,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output out_t    result_o
);

  localparam int unsigned W = OperandWidth;

  logic [W-1:0] ls_q, ls_d, rs_q, rs_d;   // dividend shift registers
  logic [W-1:0] ld_q, ld_d, rd_q, rd_d;   // divisors
  logic [W-1:0] lr_q, lr_d, rr_q, rr_d;   // partial remainders
  logic [W-1:0] lq_q, lq_d, rq_q, rq_d;   // quotients
  logic         flip_q, flip_d;

  logic [W:0]   l_trial, r_trial;
  logic         l_ge, r_ge;
  logic         verdict;

  assign l_trial = {lr_q, ls_q[W-1]};
  assign r_trial = {rr_q, rs_q[W-1]};
  assign l_ge    = l_trial >= {1'b0, ld_q};
  assign r_ge    = r_trial >= {1'b0, rd_q};

  always_comb begin
    ls_d   = ls_q;
    rs_d   = rs_q;
    ld_d   = ld_q;
    rd_d   = rd_q;
    lr_d   = lr_q;
    rr_d   = rr_q;
    lq_d   = lq_q;
    rq_d   = rq_q;
    flip_d = flip_q;
    if (cmd_i.load) begin
      ls_d   = in_data_i.left_num[W-1:0];
      ld_d   = in_data_i.left_den[W-1:0];
      rs_d   = in_data_i.right_num[W-1:0];
      rd_d   = in_data_i.right_den[W-1:0];
      lr_d   = '0;
      rr_d   = '0;
      lq_d   = '0;
      rq_d   = '0;
      flip_d = 1'b0;
    end else if (cmd_i.step) begin
      ls_d = {ls_q[W-2:0], 1'b0};
      rs_d = {rs_q[W-2:0], 1'b0};
      lr_d = l_ge ? W'(l_trial - {1'b0, ld_q}) : l_trial[W-1:0];
      rr_d = r_ge ? W'(r_trial - {1'b0, rd_q}) : r_trial[W-1:0];
      lq_d = {lq_q[W-2:0], l_ge};
      rq_d = {rq_q[W-2:0], r_ge};
    end else if (cmd_i.advance) begin
      ls_d   = ld_q;
      rs_d   = rd_q;
      ld_d   = lr_q;
      rd_d   = rr_q;
      lr_d   = '0;
      rr_d   = '0;
      lq_d   = '0;
      rq_d   = '0;
      flip_d = ~flip_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ls_q   <= ls_d;
    rs_q   <= rs_d;
    ld_q   <= ld_d;
    rd_q   <= rd_d;
    lr_q   <= lr_d;
    rr_q   <= rr_d;
    lq_q   <= lq_d;
    rq_q   <= rq_d;
    flip_q <= flip_d;
  end

  // Differing quotients decide; otherwise an exhausted remainder does.
  always_comb begin
    status_o.zero_den = (ld_q == '0) || (rd_q == '0);
    status_o.decided  = 1'b0;
    verdict           = 1'b0;
    if (lq_q != rq_q) begin
      status_o.decided = 1'b1;
      verdict          = flip_q ? (lq_q < rq_q) : (lq_q > rq_q);
    end else if ((lr_q == '0) || (rr_q == '0)) begin
      status_o.decided = 1'b1;
      if (lr_q == rr_q) begin
        verdict = 1'b1;
      end else begin
        verdict = flip_q ? (lr_q == '0) : (rr_q == '0);
      end
    end
  end

  assign result_o.zero_denominator = status_o.zero_den;
  assign result_o.at_least         = ~status_o.zero_den & verdict;

endmodule

// ----- rtl/efc_ctrl.sv -----
// ----------------------------------------------------------------------------
// efc_ctrl
// Sequencer: load, divide bit by bit, decide or take the reciprocal, hand off.
// ----------------------------------------------------------------------------
module efc_ctrl import efc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    out_free_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StCheck  = 5'b00010,
    StDiv    = 5'b00100,
    StDecide = 5'b01000,
    StDone   = 5'b10000
  } state_e;

  localparam logic [CntWidth-1:0] LastBit = CntWidth'(OperandWidth - 1);

  state_e              state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        cnt_d = '0;
        if (status_i.zero_den) begin
          state_d = StDone;
        end else begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastBit) begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        cnt_d = '0;
        if (status_i.decided) begin
          state_d = StDone;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StDiv;
        end
      end
      StDone: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/exact_fraction_compare.sv -----
// ----------------------------------------------------------------------------
// exact_fraction_compare
// Exact test of left_num/left_den >= right_num/right_den by lockstep
// continued-fraction expansion, with no product wider than an operand.
// ----------------------------------------------------------------------------
// Sequence: a zero denominator goes from accept straight to the result;
//   otherwise each expansion term runs a full division of both sides,
//   one bit per cycle in the restoring dividers, then a decide step.
// Throughput: one item at a time; the next beat is taken as soon as the
//   result sits in the output register, even while that result is stalled.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module exact_fraction_compare import efc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  // operand channel
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  // result channel
  input  logic out_stall_i,
  output logic out_valid_o,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;
  out_t    result;

  logic    out_valid_q, out_valid_d;
  out_t    out_q;
  logic    out_free;

  // The output register is free when empty or when its beat leaves now.
  assign out_free = ~out_valid_q | ~out_stall_i;

  efc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  efc_datapath u_datapath (
    .clk_i     (clk_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .result_o  (result)
  );

  // Output register: load a finished result, drop the beat once taken,
  // hold it while stalled.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A zero denominator never reports the left side as at least the right.
  a_zero_den_false: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.zero_denominator && out_data_o.at_least))
    else $error("zero_denominator with at_least set");

  // An accepted beat keeps the input side stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  // Loading a result never happens in the same cycle as taking a new beat.
  a_load_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> in_stall_o)
    else $error("result load overlaps operand accept");

endmodule
